// ===== sv/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int OUT_COUNT_W     = 24;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_PAD_EARLY  = 2'd2,
    ST_BAD_LENGTH = 2'd3
  } b64d_status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } b64d_kind_t;

  // One result item as it leaves the block
  typedef struct packed {
    b64d_kind_t             kind;
    logic [7:0]             data_byte;
    b64d_status_t           status;
    logic [OUT_COUNT_W-1:0] byte_count;
    logic                   last;
  } b64d_result_t;

  // Results produced by one input transfer: zero, one or two
  typedef struct packed {
    logic [1:0]   num;
    b64d_result_t first;
    b64d_result_t second;
  } b64d_push_t;

  // Map a character to {in_alphabet, sextet}
  function automatic logic [6:0] b64d_sextet(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
        d = c - 8'h41;
        b64d_sextet = {1'b1, d[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        d = c - 8'h61 + 8'd26;
        b64d_sextet = {1'b1, d[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30 + 8'd52;
        b64d_sextet = {1'b1, d[5:0]};
      end else if (c == 8'h2B) begin
        b64d_sextet = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
        b64d_sextet = {1'b1, 6'd63};
      end else begin
        b64d_sextet = {1'b0, d[5:0]};
      end
    end
  endfunction

endpackage

// ===== sv/b64d_core.sv =====
// ----------------------------------------------------------------------------
// b64d_core
// Per-character decode: group position, previous sextet, pad and error
// tracking, byte count, and the results each transfer produces.
// ----------------------------------------------------------------------------
module b64d_core #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           char_code,
  input  logic                 end_of_text,
  output b64d_pkg::b64d_push_t push
);
  import b64d_pkg::*;

  logic [1:0]             pos_r, pos_nxt, pos_upd;
  logic [5:0]             prev_r, prev_nxt, prev_upd;
  logic                   pad_r, pad_nxt, pad_upd;
  b64d_status_t           err_r, err_nxt, err_upd;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt, count_upd;
  logic [OUT_COUNT_W-1:0] count_out;
  logic [6:0]             lookup;
  logic                   emit;
  logic [7:0]             byte_val;
  b64d_result_t           data_res, stat_res;

  assign lookup = b64d_sextet(char_code);

  // Assemble the byte from the previous and current sextets
  always_comb begin
    case (pos_r)
      2'd1:    byte_val = {prev_r, lookup[5:4]};
      2'd2:    byte_val = {prev_r[3:0], lookup[5:2]};
      2'd3:    byte_val = {prev_r[1:0], lookup[5:0]};
      default: byte_val = 8'h00;
    endcase
  end

  // Advance decode state for one character
  always_comb begin
    prev_upd  = prev_r;
    pad_upd   = pad_r;
    err_upd   = err_r;
    count_upd = count_r;
    emit      = 1'b0;
    if (!pad_r) begin
      if (char_code == PAD_CHAR) begin
        pad_upd = 1'b1;
        if (pos_r < 2'd2 && err_r == ST_OK) begin
          err_upd = ST_PAD_EARLY;
        end
      end else if (!lookup[6]) begin
        if (err_r == ST_OK) begin
          err_upd = ST_BAD_CHAR;
        end
      end else begin
        if (pos_r != 2'd0 && err_r == ST_OK) begin
          emit = 1'b1;
          if (count_r != {COUNT_WIDTH{1'b1}}) begin
            count_upd = count_r + 1'b1;
          end
        end
        prev_upd = lookup[5:0];
      end
    end
    pos_upd = pos_r + 2'd1;
    if (pos_upd == 2'd0) begin
      pad_upd = 1'b0;
    end
  end

  // Saturate the count into the reported width
  generate
    if (COUNT_WIDTH > OUT_COUNT_W) begin : g_sat
      assign count_out = (|count_upd[COUNT_WIDTH-1:OUT_COUNT_W]) ?
                         {OUT_COUNT_W{1'b1}} : count_upd[OUT_COUNT_W-1:0];
    end else if (COUNT_WIDTH == OUT_COUNT_W) begin : g_same
      assign count_out = count_upd;
    end else begin : g_ext
      assign count_out = {{(OUT_COUNT_W-COUNT_WIDTH){1'b0}}, count_upd};
    end
  endgenerate

  // Form results and order them: data byte before status
  always_comb begin
    data_res            = '0;
    data_res.kind       = KIND_DATA;
    data_res.data_byte  = byte_val;
    data_res.status     = ST_OK;
    stat_res            = '0;
    stat_res.kind       = KIND_STATUS;
    stat_res.status     = (pos_upd != 2'd0) ? ST_BAD_LENGTH : err_upd;
    stat_res.byte_count = count_out;
    stat_res.last       = 1'b1;
    push                = '0;
    if (take) begin
      if (emit && end_of_text) begin
        push.num    = 2'd2;
        push.first  = data_res;
        push.second = stat_res;
      end else if (emit) begin
        push.num   = 2'd1;
        push.first = data_res;
      end else if (end_of_text) begin
        push.num   = 2'd1;
        push.first = stat_res;
      end
    end
  end

  // Commit state; clear it after the final character
  always_comb begin
    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    pad_nxt   = pad_r;
    err_nxt   = err_r;
    count_nxt = count_r;
    if (take) begin
      if (end_of_text) begin
        pos_nxt   = '0;
        prev_nxt  = '0;
        pad_nxt   = 1'b0;
        err_nxt   = ST_OK;
        count_nxt = '0;
      end else begin
        pos_nxt   = pos_upd;
        prev_nxt  = prev_upd;
        pad_nxt   = pad_upd;
        err_nxt   = err_upd;
        count_nxt = count_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      prev_r  <= '0;
      pad_r   <= 1'b0;
      err_r   <= ST_OK;
      count_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
      pad_r   <= pad_nxt;
      err_r   <= err_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/b64d_out_fifo.sv =====
// ----------------------------------------------------------------------------
// b64d_out_fifo
// Small result queue: takes up to two results per cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module b64d_out_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  b64d_pkg::b64d_push_t   push,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_ready,
  output b64d_pkg::b64d_result_t head
);
  import b64d_pkg::*;

  b64d_result_t            entry_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic                    pop;

  // Keep space for a worst-case transfer of two results
  assign room      = (count_r < FIFO_CNT_W'(FIFO_DEPTH - 1));
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = entry_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.num[FIFO_PTR_W-1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop);
  end

  // Write the stored entries
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entry_r[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      entry_r[wr_ptr_p1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 (standard alphabet, '=' pad) decoder with final status.
// ----------------------------------------------------------------------------
// One character is taken per cycle while in_ready is high. Each alphabet
// character at position 1..3 of a group, before any pad or error, yields a
// data byte; the character flagged end_of_text also yields a status result
// (ok, bad character, early pad, bad length) with the saturating byte count,
// after any data byte from that character. The decode is one registered pass
// from the input transfer into a four-entry result queue. in_ready depends
// only on the queue fill: with out_ready held high, one character per cycle
// is sustained; the two results of one character leave the port in turn.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_char_code,
  input  logic                              in_end_of_text,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [7:0]                        out_data_byte,
  output logic [1:0]                        out_status,
  output logic [b64d_pkg::OUT_COUNT_W-1:0]  out_byte_count,
  output logic                              out_last
);
  import b64d_pkg::*;

  b64d_push_t   push;
  b64d_result_t head;
  logic         take;

  assign take = in_valid && in_ready;

  // Decode one character per transfer
  b64d_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .char_code   (in_char_code),
    .end_of_text (in_end_of_text),
    .push        (push)
  );

  // Queue results toward the output
  b64d_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind       = head.kind;
  assign out_data_byte  = head.data_byte;
  assign out_status     = head.status;
  assign out_byte_count = head.byte_count;
  assign out_last       = head.last;

endmodule
